[design/fta_pkg.sv]
// Shared types and constants for the frame table clock allocator.
// Used by fta_frame_store, fta_ctrl and frame_table_clock_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

	localparam int FRAME_COUNT = 1024;
	localparam int IDX_W       = $clog2(FRAME_COUNT);
	localparam int CNT_W       = IDX_W + 1;  // holds FRAME_COUNT itself
	localparam int STEP_W      = IDX_W + 2;  // holds two rotations
	localparam int LINK_W      = CNT_W;      // a link may hold the empty marker

	localparam logic [CNT_W-1:0] HEAD_EMPTY = CNT_W'(FRAME_COUNT);
	localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(FRAME_COUNT);

	// frame flag bits
	localparam int FLAG_VALID = 0;
	localparam int FLAG_SWAP  = 1;
	localparam int FLAG_REF   = 2;

	localparam logic [2:0] FLAGS_FRESH = 3'b111;
	localparam logic [2:0] FLAGS_FIXED = 3'b101;
	localparam logic [2:0] FLAGS_NONE  = 3'b000;

	// opcodes
	localparam logic [2:0] OP_ALLOC        = 3'd0;
	localparam logic [2:0] OP_ALLOC_UNSWAP = 3'd1;
	localparam logic [2:0] OP_FREE         = 3'd2;
	localparam logic [2:0] OP_PIN          = 3'd3;
	localparam logic [2:0] OP_UNPIN        = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd1;
	localparam logic [1:0] ST_NO_VICTIM = 2'd2;

	typedef struct packed {
		logic              flag_rd_en;
		logic [IDX_W-1:0]  flag_rd_addr;
		logic              flag_wr_en;
		logic [IDX_W-1:0]  flag_wr_addr;
		logic [2:0]        flag_wr_data;
		logic              link_rd_en;
		logic [IDX_W-1:0]  link_rd_addr;
		logic              link_wr_en;
		logic [IDX_W-1:0]  link_wr_addr;
		logic [LINK_W-1:0] link_wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] victim;
		logic             evicted;
		logic [IDX_W-1:0] granted;
	} result_t;

endpackage

`default_nettype wire

[design/fta_frame_store.sv]
// Frame flag memory and free-list link memory, registered reads.
// Depends on fta_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module fta_frame_store
	import fta_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic [2:0]             flag_rd_data,
	output logic [LINK_W-1:0]      link_rd_data
);

	logic [2:0]        flag_mem [FRAME_COUNT];
	logic [LINK_W-1:0] link_mem [FRAME_COUNT];

	always_ff @(posedge clk) begin
		if (req.flag_wr_en) begin
			flag_mem[req.flag_wr_addr] <= req.flag_wr_data;
		end
		if (req.flag_rd_en) begin
			flag_rd_data <= flag_mem[req.flag_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.link_wr_en) begin
			link_mem[req.link_wr_addr] <= req.link_wr_data;
		end
		if (req.link_rd_en) begin
			link_rd_data <= link_mem[req.link_rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/fta_ctrl.sv]
// Request sequencer: free list, fresh handout, clock sweep, pin and unpin.
// Depends on fta_pkg; drives fta_frame_store through a mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module fta_ctrl
	import fta_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        in_op,
	input  wire logic [IDX_W-1:0]  in_idx,
	input  wire logic [CNT_W-1:0]  frame_limit,
	output mem_req_t               req,
	input  wire logic [2:0]        flag_rd_data,
	input  wire logic [LINK_W-1:0] link_rd_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output result_t                res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SW_RD,
		ST_SW_EV
	} state_t;

	state_t             state_q, state_nxt;
	logic [2:0]         op_q, op_nxt;
	logic [IDX_W-1:0]   idx_q, idx_nxt;
	logic [CNT_W-1:0]   head_q, head_nxt;
	logic [CNT_W-1:0]   fresh_q, fresh_nxt;
	logic [IDX_W-1:0]   hand_q, hand_nxt;
	logic [IDX_W-1:0]   cur_q, cur_nxt;
	logic [STEP_W-1:0]  step_q, step_nxt;

	logic [2:0]         fl_alloc;
	logic [2:0]         f_idx;
	logic [2:0]         f_cur;
	logic [CNT_W-1:0]   cur_inc;
	logic [IDX_W-1:0]   cur_wrap;
	logic               done;

	assign in_ready = (state_q == ST_IDLE);
	assign fl_alloc = (op_q == OP_ALLOC_UNSWAP) ? FLAGS_FIXED : FLAGS_FRESH;
	// frames at or past the fill count were never handed out: flags read as zero
	assign f_idx    = ({1'b0, idx_q} < fresh_q) ? flag_rd_data : FLAGS_NONE;
	assign f_cur    = ({1'b0, cur_q} < fresh_q) ? flag_rd_data : FLAGS_NONE;
	assign cur_inc  = {1'b0, cur_q} + CNT_W'(1);
	assign cur_wrap = (cur_inc == frame_limit) ? '0 : cur_inc[IDX_W-1:0];
	assign done     = res_valid && res_ready;

	always_comb begin
		state_nxt = state_q;
		op_nxt    = op_q;
		idx_nxt   = idx_q;
		head_nxt  = head_q;
		fresh_nxt = fresh_q;
		hand_nxt  = hand_q;
		cur_nxt   = cur_q;
		step_nxt  = step_q;
		req       = '0;
		res       = '0;
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_nxt            = in_op;
					idx_nxt           = in_idx;
					state_nxt         = ST_EXEC;
					req.flag_rd_en    = 1'b1;
					req.flag_rd_addr  = in_idx;
					req.link_rd_en    = 1'b1;
					req.link_rd_addr  = head_q[IDX_W-1:0];
				end
			end

			ST_EXEC: begin
				unique case (op_q)
					OP_ALLOC, OP_ALLOC_UNSWAP: begin
						if (head_q != HEAD_EMPTY) begin
							res_valid   = 1'b1;
							res.granted = head_q[IDX_W-1:0];
							if (res_ready) begin
								req.flag_wr_en   = 1'b1;
								req.flag_wr_addr = head_q[IDX_W-1:0];
								req.flag_wr_data = fl_alloc;
								head_nxt         = link_rd_data;
							end
						end else if (fresh_q < frame_limit) begin
							res_valid   = 1'b1;
							res.granted = fresh_q[IDX_W-1:0];
							if (res_ready) begin
								req.flag_wr_en   = 1'b1;
								req.flag_wr_addr = fresh_q[IDX_W-1:0];
								req.flag_wr_data = fl_alloc;
								fresh_nxt        = fresh_q + CNT_W'(1);
							end
						end else begin
							// hand left past a shrunk limit restarts at frame zero
							cur_nxt   = ({1'b0, hand_q} < frame_limit) ? hand_q : '0;
							step_nxt  = '0;
							state_nxt = ST_SW_RD;
						end
					end
					OP_FREE: begin
						res_valid = 1'b1;
						if ({1'b0, idx_q} < fresh_q) begin
							if (res_ready) begin
								req.flag_wr_en   = 1'b1;
								req.flag_wr_addr = idx_q;
								req.flag_wr_data = FLAGS_NONE;
								req.link_wr_en   = 1'b1;
								req.link_wr_addr = idx_q;
								req.link_wr_data = head_q;
								head_nxt         = {1'b0, idx_q};
							end
						end else begin
							res.status = ST_NOT_ALLOC;
						end
					end
					OP_PIN: begin
						res_valid = 1'b1;
						if (res_ready && f_idx[FLAG_VALID] && f_idx[FLAG_SWAP]) begin
							req.flag_wr_en             = 1'b1;
							req.flag_wr_addr           = idx_q;
							req.flag_wr_data           = f_idx;
							req.flag_wr_data[FLAG_REF] = 1'b1;
							req.flag_wr_data[FLAG_SWAP] = 1'b0;
						end
					end
					OP_UNPIN: begin
						res_valid = 1'b1;
						if (res_ready && f_idx[FLAG_VALID]) begin
							req.flag_wr_en              = 1'b1;
							req.flag_wr_addr            = idx_q;
							req.flag_wr_data            = f_idx;
							req.flag_wr_data[FLAG_SWAP] = 1'b1;
						end
					end
					default: begin
						res_valid = 1'b1;
					end
				endcase
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end

			ST_SW_RD: begin
				if (step_q == {frame_limit, 1'b0}) begin
					// two full rotations without a victim
					res_valid  = 1'b1;
					res.status = ST_NO_VICTIM;
					if (res_ready) begin
						state_nxt = ST_IDLE;
					end
				end else begin
					req.flag_rd_en   = 1'b1;
					req.flag_rd_addr = cur_q;
					state_nxt        = ST_SW_EV;
				end
			end

			ST_SW_EV: begin
				if (f_cur[FLAG_VALID] && f_cur[FLAG_SWAP] && !f_cur[FLAG_REF]) begin
					res_valid   = 1'b1;
					res.granted = cur_q;
					res.evicted = 1'b1;
					res.victim  = cur_q;
					if (res_ready) begin
						req.flag_wr_en   = 1'b1;
						req.flag_wr_addr = cur_q;
						req.flag_wr_data = fl_alloc;
						hand_nxt         = cur_wrap;
						state_nxt        = ST_IDLE;
					end
				end else begin
					if (f_cur[FLAG_VALID] && f_cur[FLAG_SWAP]) begin
						req.flag_wr_en             = 1'b1;
						req.flag_wr_addr           = cur_q;
						req.flag_wr_data           = f_cur;
						req.flag_wr_data[FLAG_REF] = 1'b0;
					end
					cur_nxt   = cur_wrap;
					step_nxt  = step_q + STEP_W'(1);
					state_nxt = ST_SW_RD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ALLOC;
			idx_q   <= '0;
			head_q  <= HEAD_EMPTY;
			fresh_q <= '0;
			hand_q  <= '0;
			cur_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			op_q    <= op_nxt;
			idx_q   <= idx_nxt;
			head_q  <= head_nxt;
			fresh_q <= fresh_nxt;
			hand_q  <= hand_nxt;
			cur_q   <= cur_nxt;
			step_q  <= step_nxt;
		end
	end

endmodule

`default_nettype wire

[design/frame_table_clock_allocator_unit.sv]
// Top level of the frame table clock allocator: stream ports, limit register,
// result register. Depends on fta_pkg, fta_ctrl and fta_frame_store.
//
// Manages 1024 physical frames with a LIFO free list, a fill count for frames
// never handed out, and a second-chance clock sweep. Every request returns one
// result. Free, pin, unpin, unknown opcodes and allocations served from the
// free list or the fill count read the frame store, then modify and write
// back. An allocation that needs the clock sweep then reads each frame
// examined and evaluates and writes back the same entry, and reports a
// failed sweep once two full rotations over the managed frames find no
// victim. The fill count stands in for clearing the flag store, so the
// block is ready directly after reset. A result waiting on the output
// register stalls the sequencer only at a step that hands over a result.
// The limit register (reset 1024; 0 acts as 1, above 1024 as 1024) is
// always ready and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module frame_table_clock_allocator_unit
	import fta_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // opcode[2:0], frame_no[12:3], zero pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // granted_index[9:0], evicted[10],
	                                        // victim_index[20:11], status[22:21], pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data       // frames_in_use
);

	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  frame_limit;
	mem_req_t          req;
	logic [2:0]        flag_rd_data;
	logic [LINK_W-1:0] link_rd_data;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	result_t           out_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= COUNT_MAX;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_comb begin
		priority if (limit_q == '0) begin
			frame_limit = CNT_W'(1);
		end else if (limit_q > COUNT_MAX) begin
			frame_limit = COUNT_MAX;
		end else begin
			frame_limit = limit_q;
		end
	end

	fta_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tdata[2:0]),
		.in_idx       (s_axis_tdata[12:3]),
		.frame_limit  (frame_limit),
		.req          (req),
		.flag_rd_data (flag_rd_data),
		.link_rd_data (link_rd_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	fta_frame_store u_store (
		.clk          (clk),
		.req          (req),
		.flag_rd_data (flag_rd_data),
		.link_rd_data (link_rd_data)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire

[tb/sv/tb_frame_table_clock_allocator_unit.sv]
// Self-checking bench for frame_table_clock_allocator_unit: directed and random
// allocate/free/pin/unpin requests against an in-bench frame table predictor.
// Depends on fta_pkg and the RTL of the allocator only.
`timescale 1ns / 1ps

module tb_frame_table_clock_allocator_unit;
	import fta_pkg::*;

	localparam int SWEEP_LAT   = 3 + 4 * FRAME_COUNT;  // two fruitless rotations
	localparam int QUIET_LIMIT = 5 * SWEEP_LAT;
	localparam int HOLD_CYCLES = 300;

	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data      = '0;

	// predicted frame table
	logic [2:0]        tbl_flags [FRAME_COUNT];
	logic              tbl_used  [FRAME_COUNT];
	logic [LINK_W-1:0] tbl_link  [FRAME_COUNT];
	logic [CNT_W-1:0]  list_head;
	logic [IDX_W-1:0]  hand_pos;
	logic [CNT_W-1:0]  fill_count;
	logic [10:0]       limit_reg;

	result_t outcome_q [$];

	bit          idle_en   = 1'b1;
	int unsigned hold_req  = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet     = 0;

	int fail_cnt      = 0;
	int req_cnt       = 0;
	int result_cnt    = 0;
	int evict_cnt     = 0;
	int no_victim_cnt = 0;
	int bad_free_cnt  = 0;
	int limit_cnt     = 0;

	frame_table_clock_allocator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int managed();
		if (limit_reg == 0)
			return 1;
		if (limit_reg > COUNT_MAX)
			return FRAME_COUNT;
		return int'(limit_reg);
	endfunction

	// second-chance sweep; clears reference bits on the way
	function automatic bit sweep_victim(output logic [IDX_W-1:0] victim);
		int n;
		int i;
		n = managed();
		i = (int'(hand_pos) < n) ? int'(hand_pos) : 0;
		victim = '0;
		for (int step = 0; step < 2 * n; step++) begin
			if (tbl_flags[i][FLAG_VALID] && tbl_flags[i][FLAG_SWAP]) begin
				if (tbl_flags[i][FLAG_REF]) begin
					tbl_flags[i][FLAG_REF] = 1'b0;
				end else begin
					victim = IDX_W'(i);
					hand_pos = IDX_W'((i + 1) % n);
					return 1'b1;
				end
			end
			i = (i + 1) % n;
		end
		return 1'b0;
	endfunction

	function automatic result_t table_outcome(input logic [2:0] op, input logic [IDX_W-1:0] idx);
		result_t r;
		logic [IDX_W-1:0] g;
		r = '0;
		g = '0;
		case (op)
		OP_ALLOC, OP_ALLOC_UNSWAP: begin
			if (list_head < COUNT_MAX) begin
				g = list_head[IDX_W-1:0];
				list_head = tbl_link[g];
			end else if (int'(fill_count) < managed()) begin
				g = fill_count[IDX_W-1:0];
				fill_count = fill_count + 1'b1;
				tbl_used[g] = 1'b1;
			end else if (sweep_victim(g)) begin
				r.evicted = 1'b1;
				r.victim = g;
				evict_cnt++;
			end else begin
				r.status = ST_NO_VICTIM;
				no_victim_cnt++;
			end
			if (r.status == ST_OK) begin
				tbl_flags[g] = (op == OP_ALLOC_UNSWAP) ? FLAGS_FIXED : FLAGS_FRESH;
				r.granted = g;
			end
		end
		OP_FREE: begin
			if (!tbl_used[idx]) begin
				r.status = ST_NOT_ALLOC;
				bad_free_cnt++;
			end else begin
				tbl_flags[idx] = FLAGS_NONE;
				tbl_link[idx] = list_head;
				list_head = {1'b0, idx};
			end
		end
		OP_PIN: begin
			if (tbl_flags[idx][FLAG_VALID] && tbl_flags[idx][FLAG_SWAP]) begin
				tbl_flags[idx][FLAG_REF] = 1'b1;
				tbl_flags[idx][FLAG_SWAP] = 1'b0;
			end
		end
		OP_UNPIN: begin
			if (tbl_flags[idx][FLAG_VALID])
				tbl_flags[idx][FLAG_SWAP] = 1'b1;
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		fail_cnt++;
	endtask

	task automatic check_outcome(input result_t got);
		result_t want;
		result_cnt++;
		if (outcome_q.size() == 0) begin
			report_mismatch("result with no request pending, granted", got.granted, 0);
		end else begin
			want = outcome_q.pop_front();
			if (got.granted !== want.granted)
				report_mismatch("granted_index", got.granted, want.granted);
			if (got.evicted !== want.evicted)
				report_mismatch("evicted", got.evicted, want.evicted);
			if (got.victim !== want.victim)
				report_mismatch("victim_index", got.victim, want.victim);
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
		end
	endtask

	// result side: check, then pick tready for the next edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_outcome(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !idle_en || ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_req(input logic [2:0] op, input logic [IDX_W-1:0] idx);
		if (idle_en && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, idx, op};
		do @(posedge clk); while (!s_axis_tready);
		outcome_q.push_back(table_outcome(op, idx));
		req_cnt++;
	endtask

	task automatic release_bus();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		release_bus();
		while (outcome_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_limit(input logic [10:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = value;
		limit_cnt++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed requests on handed-out frames, some noise
	task automatic random_request();
		int pick;
		logic [2:0] op;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(99);
		if (pick < 38)
			op = OP_ALLOC;
		else if (pick < 48)
			op = OP_ALLOC_UNSWAP;
		else if (pick < 66)
			op = OP_FREE;
		else if (pick < 80)
			op = OP_PIN;
		else if (pick < 94)
			op = OP_UNPIN;
		else
			op = 3'($urandom_range(7));
		if ($urandom_range(3) == 0)
			idx = IDX_W'($urandom_range(FRAME_COUNT - 1));
		else
			idx = IDX_W'($urandom_range(managed() - 1));
		// a frame already on the free list would loop the list for good
		if (op == OP_FREE && tbl_used[idx] && !tbl_flags[idx][FLAG_VALID])
			op = OP_PIN;
		send_req(op, idx);
	endtask

	task automatic test_unused_frames();
		send_req(OP_FREE, 10'd0);
		send_req(OP_PIN, 10'd5);
		send_req(OP_UNPIN, 10'h3FF);
		send_req(OP_SPARE_5, 10'h3FF);
		send_req(OP_SPARE_6, 10'h155);
		send_req(OP_SPARE_7, 10'd0);
		send_req(OP_ALLOC, 10'h3FF);
		send_req(OP_ALLOC_UNSWAP, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_PIN, 10'd0);
		send_req(OP_UNPIN, 10'd1);
		send_req(OP_FREE, 10'd2);
		send_req(OP_ALLOC, 10'd0);
	endtask

	task automatic test_limit_extremes();
		write_limit(11'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_UNPIN, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		write_limit(11'd1);
		send_req(OP_ALLOC_UNSWAP, 10'd0);
		write_limit(11'd2047);
		send_req(OP_ALLOC, 10'd0);
	endtask

	task automatic test_clock_sweep();
		write_limit(11'd4);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_PIN, 10'd2);
		send_req(OP_ALLOC_UNSWAP, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		// hand now past the shrunk range
		write_limit(11'd2);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_PIN, 10'd1);
		send_req(OP_ALLOC, 10'd0);
	endtask

	task automatic test_backpressure();
		write_limit(11'd8);
		hold_req <= hold_req + 1;
		repeat (24) random_request();
	endtask

	task automatic test_random_mix();
		logic [10:0] limits [6];
		limits = '{11'd16, 11'd5, 11'd40, 11'd1024, 11'd2, 11'd12};
		foreach (limits[k]) begin
			write_limit(limits[k]);
			idle_en = (k != 2);
			repeat (62) random_request();
		end
		idle_en = 1'b1;
	endtask

	// run last: a second free of the same frame leaves the list cycling for good
	task automatic test_repeated_free();
		int victim_frame;
		victim_frame = 0;
		send_req(OP_ALLOC, 10'd0);
		for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
			if (tbl_flags[f][FLAG_VALID])
				victim_frame = f;
		end
		send_req(OP_FREE, IDX_W'(victim_frame));
		send_req(OP_FREE, IDX_W'(victim_frame));
		repeat (3) send_req(OP_ALLOC, 10'd0);
		repeat (10) random_request();
	endtask

	initial begin
		foreach (tbl_flags[f]) begin
			tbl_flags[f] = FLAGS_NONE;
			tbl_used[f] = 1'b0;
			tbl_link[f] = '0;
		end
		list_head = HEAD_EMPTY;
		hand_pos = '0;
		fill_count = '0;
		limit_reg = 11'd1024;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unused_frames();
		test_limit_extremes();
		test_clock_sweep();
		test_backpressure();
		test_random_mix();
		test_repeated_free();

		wait_drain();
		repeat (SWEEP_LAT) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d evictions, %0d with no victim",
			req_cnt, result_cnt, evict_cnt, no_victim_cnt);
		$display("%0d frees of unused frames, %0d limit writes (0, 1, 2, 1024, 2047 among them)",
			bad_free_cnt, limit_cnt);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
